### rtl/core/utisd_pkg.sv
// shared types and codes for the unsorted table block
`timescale 1ns / 1ps
`default_nettype none

package utisd_pkg;

	// operation codes carried in the mode field
	typedef enum logic [1:0] {
		MODE_SEARCH = 2'd0,
		MODE_INSERT = 2'd1,
		MODE_DELETE = 2'd2
	} mode_t;

	// completion status codes
	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_FULL  = 2'd1,
		STATUS_RANGE = 2'd2
	} status_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_INSERT,
		ST_DELETE,
		ST_DONE
	} state_t;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned POS_W   = 7;
	localparam int unsigned CNT_W   = 7;

endpackage

`default_nettype wire

### rtl/core/utisd_if.sv
// request and response channel interfaces for the unsorted table block
`timescale 1ns / 1ps
`default_nettype none

interface utisd_req_if;
	logic                                  valid;
	logic                                  ready;
	logic [1:0]                            mode;
	logic signed [utisd_pkg::VALUE_W-1:0]  value;
	logic [utisd_pkg::POS_W-1:0]           position;

	modport source (output valid, output mode, output value, output position, input ready);
	modport sink   (input valid, input mode, input value, input position, output ready);
endinterface

interface utisd_rsp_if;
	logic                          valid;
	logic                          ready;
	logic                          found;
	logic [utisd_pkg::CNT_W-1:0]   removed_count;
	logic [utisd_pkg::CNT_W-1:0]   entry_count;
	logic [1:0]                    status;

	modport source (output valid, output found, output removed_count, output entry_count,
		output status, input ready);
	modport sink   (input valid, input found, input removed_count, input entry_count,
		input status, output ready);
endinterface

`default_nettype wire

### rtl/core/unsorted_table_insert_search_delete_top.sv
// unsorted table with search, positional insert and delete of all matches
// one transaction at a time; a single memory port pair is stepped by a sequencer
// search reads entries in order until a match; delete rewrites survivors to the front
// insert moves each entry above the slot up one place; rejected inserts touch no entry
// async reset empties the table (count zero); entry contents stay undefined
`timescale 1ns / 1ps
`default_nettype none

module unsorted_table_insert_search_delete_top #(
	parameter int unsigned DEPTH = 64
) (
	input  wire           clk,
	input  wire           arst_n,
	utisd_req_if.sink     req,
	utisd_rsp_if.source   rsp
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned PW = ((CW > utisd_pkg::POS_W) ? CW : utisd_pkg::POS_W) + 1;

	// table storage
	logic [utisd_pkg::VALUE_W-1:0] mem [DEPTH];
	logic [utisd_pkg::VALUE_W-1:0] rd_q;
	logic                          mem_we;
	logic [AW-1:0]                 mem_waddr;
	logic [AW-1:0]                 mem_raddr;
	logic [utisd_pkg::VALUE_W-1:0] mem_wdata;

	// sequencer and working registers
	utisd_pkg::state_t             state_q, state_d;
	logic                          phase_q, phase_d;
	logic [CW-1:0]                 idx_q, idx_d;
	logic [CW-1:0]                 keep_q, keep_d;
	logic [CW-1:0]                 slot_q, slot_d;
	logic [CW-1:0]                 count_q, count_d;
	logic [CW-1:0]                 removed_q, removed_d;
	logic                          found_q, found_d;
	utisd_pkg::status_t            status_q, status_d;
	logic [utisd_pkg::VALUE_W-1:0] value_q, value_d;

	// response register
	logic                          rsp_valid_q, rsp_valid_d;
	logic                          rsp_found_q, rsp_found_d;
	logic [utisd_pkg::CNT_W-1:0]   rsp_removed_q, rsp_removed_d;
	logic [utisd_pkg::CNT_W-1:0]   rsp_count_q, rsp_count_d;
	utisd_pkg::status_t            rsp_status_q, rsp_status_d;

	logic [CW-1:0]                 idx_m1;
	logic [PW-1:0]                 pos_ext;
	logic [PW-1:0]                 limit_ext;
	logic                          pos_bad;
	logic                          hit;

	assign idx_m1    = idx_q - CW'(1);
	assign pos_ext   = PW'(req.position);
	assign limit_ext = PW'(count_q) + PW'(1);
	assign pos_bad   = (req.position == '0) || (pos_ext > limit_ext);
	assign hit       = (rd_q == value_q);

	assign req.ready         = (state_q == utisd_pkg::ST_IDLE);
	assign rsp.valid         = rsp_valid_q;
	assign rsp.found         = rsp_found_q;
	assign rsp.removed_count = rsp_removed_q;
	assign rsp.entry_count   = rsp_count_q;
	assign rsp.status        = rsp_status_q;

	// memory port, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_q <= mem[mem_raddr];
	end

	// next state and datapath control
	always_comb begin
		state_d       = state_q;
		phase_d       = phase_q;
		idx_d         = idx_q;
		keep_d        = keep_q;
		slot_d        = slot_q;
		count_d       = count_q;
		removed_d     = removed_q;
		found_d       = found_q;
		status_d      = status_q;
		value_d       = value_q;
		rsp_valid_d   = rsp_valid_q && !rsp.ready;
		rsp_found_d   = rsp_found_q;
		rsp_removed_d = rsp_removed_q;
		rsp_count_d   = rsp_count_q;
		rsp_status_d  = rsp_status_q;
		mem_we        = 1'b0;
		mem_waddr     = idx_q[AW-1:0];
		mem_wdata     = rd_q;
		mem_raddr     = idx_q[AW-1:0];

		case (state_q)
			utisd_pkg::ST_IDLE: begin
				if (req.valid) begin
					value_d   = req.value;
					idx_d     = '0;
					keep_d    = '0;
					removed_d = '0;
					found_d   = 1'b0;
					status_d  = utisd_pkg::STATUS_OK;
					phase_d   = 1'b0;
					case (utisd_pkg::mode_t'(req.mode))
						utisd_pkg::MODE_SEARCH: state_d = utisd_pkg::ST_SEARCH;
						utisd_pkg::MODE_INSERT: begin
							if (count_q >= CW'(DEPTH)) begin
								status_d = utisd_pkg::STATUS_FULL;
								state_d  = utisd_pkg::ST_DONE;
							end else if (pos_bad) begin
								status_d = utisd_pkg::STATUS_RANGE;
								state_d  = utisd_pkg::ST_DONE;
							end else begin
								idx_d   = count_q;
								slot_d  = CW'(req.position - utisd_pkg::POS_W'(1));
								state_d = utisd_pkg::ST_INSERT;
							end
						end
						utisd_pkg::MODE_DELETE: state_d = utisd_pkg::ST_DELETE;
						default: state_d = utisd_pkg::ST_DONE;
					endcase
				end
			end

			// scan entries in order until a match or the end
			utisd_pkg::ST_SEARCH: begin
				if (!phase_q) begin
					if (idx_q >= count_q) begin
						state_d = utisd_pkg::ST_DONE;
					end else begin
						phase_d = 1'b1;
					end
				end else begin
					phase_d = 1'b0;
					if (hit) begin
						found_d = 1'b1;
						state_d = utisd_pkg::ST_DONE;
					end else begin
						idx_d = idx_q + CW'(1);
					end
				end
			end

			// shift entries up from the top down to the slot, then drop the value in
			utisd_pkg::ST_INSERT: begin
				if (!phase_q) begin
					if (idx_q == slot_q) begin
						mem_we    = 1'b1;
						mem_waddr = slot_q[AW-1:0];
						mem_wdata = value_q;
						count_d   = count_q + CW'(1);
						state_d   = utisd_pkg::ST_DONE;
					end else begin
						mem_raddr = idx_m1[AW-1:0];
						phase_d   = 1'b1;
					end
				end else begin
					mem_we    = 1'b1;
					mem_waddr = idx_q[AW-1:0];
					idx_d     = idx_m1;
					phase_d   = 1'b0;
				end
			end

			// compact survivors toward the front, counting matches
			utisd_pkg::ST_DELETE: begin
				if (!phase_q) begin
					if (idx_q >= count_q) begin
						count_d = keep_q;
						state_d = utisd_pkg::ST_DONE;
					end else begin
						phase_d = 1'b1;
					end
				end else begin
					phase_d = 1'b0;
					idx_d   = idx_q + CW'(1);
					if (hit) begin
						removed_d = removed_q + CW'(1);
					end else begin
						mem_we    = 1'b1;
						mem_waddr = keep_q[AW-1:0];
						keep_d    = keep_q + CW'(1);
					end
				end
			end

			// hand the result to the response register once it is free
			utisd_pkg::ST_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					rsp_valid_d   = 1'b1;
					rsp_found_d   = found_q;
					rsp_removed_d = utisd_pkg::CNT_W'(removed_q);
					rsp_count_d   = utisd_pkg::CNT_W'(count_q);
					rsp_status_d  = status_q;
					state_d       = utisd_pkg::ST_IDLE;
				end
			end

			default: state_d = utisd_pkg::ST_IDLE;
		endcase
	end

	// control and working registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= utisd_pkg::ST_IDLE;
			phase_q     <= 1'b0;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			phase_q     <= phase_d;
			count_q     <= count_d;
			rsp_valid_q <= rsp_valid_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		idx_q         <= idx_d;
		keep_q        <= keep_d;
		slot_q        <= slot_d;
		removed_q     <= removed_d;
		found_q       <= found_d;
		status_q      <= status_d;
		value_q       <= value_d;
		rsp_found_q   <= rsp_found_d;
		rsp_removed_q <= rsp_removed_d;
		rsp_count_q   <= rsp_count_d;
		rsp_status_q  <= rsp_status_d;
	end

endmodule

`default_nettype wire

### rtl/core/utisd_checker.sv
// port-level assertions for the unsorted table block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module utisd_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          req_valid,
	input wire                          req_ready,
	input wire                          rsp_valid,
	input wire                          rsp_ready,
	input wire                          rsp_found,
	input wire [utisd_pkg::CNT_W-1:0]   rsp_removed_count,
	input wire [1:0]                    rsp_status
);

	// a pending response holds until taken
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped before it was taken");

	// the block is busy right after taking a transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken while previous transaction in flight");

	// a search hit carries no removal count and an ok status
	a_found_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_found |->
			rsp_removed_count == '0 && rsp_status == utisd_pkg::STATUS_OK)
		else $error("search hit mixed with other result fields");

	// a rejected insert reports no hit and no removals
	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != utisd_pkg::STATUS_OK |->
			!rsp_found && rsp_removed_count == '0)
		else $error("rejected insert mixed with other result fields");

endmodule

bind unsorted_table_insert_search_delete_top utisd_checker u_utisd_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_found         (rsp.found),
	.rsp_removed_count (rsp.removed_count),
	.rsp_status        (rsp.status)
);

`default_nettype wire
